FILE: rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants for the character LCD number writer
// Payload structs, job descriptor passed from front to back, LCD byte codes.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

   // request codes
   localparam logic [2:0] CMD_INIT = 3'd0;
   localparam logic [2:0] CMD_CHAR = 3'd1;
   localparam logic [2:0] CMD_UDEC = 3'd2;
   localparam logic [2:0] CMD_SDEC = 3'd3;
   localparam logic [2:0] CMD_HEX  = 3'd4;
   localparam logic [2:0] CMD_BIN  = 3'd5;

   // controller command bytes
   localparam logic [7:0] LCD_SET_ADDR  = 8'h80;
   localparam logic [7:0] LCD_LINE2     = 8'h40;
   localparam logic [7:0] LCD_FUNC_SET  = 8'h38;
   localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY     = 8'h06;
   localparam logic [7:0] LCD_CLEAR     = 8'h01;

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam int DEC_PLACES = 5;  // decimal places a 16-bit value can fill

   typedef enum logic [2:0] {
      OP_INIT,
      OP_CHAR,
      OP_UDEC,
      OP_SDEC,
      OP_HEX,
      OP_BIN
   } op_type;

   typedef enum logic [2:0] {
      PH_ADDR,
      PH_INIT,
      PH_CHAR,
      PH_SIGN,
      PH_SKIP,
      PH_DIGIT
   } phase_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  line;
      logic [5:0]  column;
      logic [15:0] value;
      logic [4:0]  digit_count;
   } req_payload_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      op_type      kind;
      logic [7:0]  addr_byte;
      logic [15:0] value;
      logic        positive;
   } job_type;

endpackage

FILE: rtl/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front: request decode
// Classifies a request, forms the set-address byte, the magnitude for signed
// mode and the clamped digit count, and flags unknown commands to be dropped.
// ----------------------------------------------------------------------------
module lcdnw_front #(
   parameter int MAX_DIGITS = 16
) (
   input  lcdnw_pkg::req_payload_type        req_payload,
   output logic                              keep,
   output lcdnw_pkg::job_type                job,
   output logic [$clog2(MAX_DIGITS+1)-1:0]   count
);

   localparam int CntW = $clog2(MAX_DIGITS + 1);

   logic [7:0]          addr;
   logic                positive;
   lcdnw_pkg::op_type   kind;

   always_comb begin
      keep = 1'b1;
      kind = lcdnw_pkg::OP_INIT;
      unique case (req_payload.cmd)
         lcdnw_pkg::CMD_INIT: kind = lcdnw_pkg::OP_INIT;
         lcdnw_pkg::CMD_CHAR: kind = lcdnw_pkg::OP_CHAR;
         lcdnw_pkg::CMD_UDEC: kind = lcdnw_pkg::OP_UDEC;
         lcdnw_pkg::CMD_SDEC: kind = lcdnw_pkg::OP_SDEC;
         lcdnw_pkg::CMD_HEX:  kind = lcdnw_pkg::OP_HEX;
         lcdnw_pkg::CMD_BIN:  kind = lcdnw_pkg::OP_BIN;
         default:             keep = 1'b0;
      endcase
   end

   // column counts from 1; wraps modulo 256
   always_comb begin
      addr = 8'(req_payload.column) - 8'd1;
      if (req_payload.line != 2'd1) begin
         addr = addr + lcdnw_pkg::LCD_LINE2;
      end
   end

   // zero counts as negative, so it shows '-'
   assign positive = (req_payload.value != 16'd0) && !req_payload.value[15];

   assign job.kind      = kind;
   assign job.addr_byte = lcdnw_pkg::LCD_SET_ADDR | addr;
   assign job.positive  = positive;
   assign job.value     = (req_payload.cmd == lcdnw_pkg::CMD_SDEC && !positive)
                          ? (16'd0 - req_payload.value) : req_payload.value;

   assign count = (req_payload.digit_count > 5'(MAX_DIGITS))
                  ? CntW'(MAX_DIGITS) : CntW'(req_payload.digit_count);

endmodule

FILE: rtl/lcdnw_queue.sv
// ----------------------------------------------------------------------------
// lcdnw_queue: two-entry job queue
// Decouples request decode from byte generation so each side stalls alone.
// ----------------------------------------------------------------------------
module lcdnw_queue #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PtrW  = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == (PtrW+1)'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back: byte sequencer
// Walks one job at a time through address, init, character, sign, skip and digit
// phases, one byte write per cycle while not stalled or skipping, into a registered output stage.
// ----------------------------------------------------------------------------
module lcdnw_back #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  lcdnw_pkg::job_type               q_job,
   input  logic [$clog2(MAX_DIGITS+1)-1:0]  q_count,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lcdnw_pkg::rsp_payload_type       rsp_payload
);

   localparam int CntW = $clog2(MAX_DIGITS + 1);

   function automatic logic [16:0] pow10(input logic [2:0] place);
      logic [16:0] p;
      unique case (place)
         3'd0:    p = 17'd1;
         3'd1:    p = 17'd10;
         3'd2:    p = 17'd100;
         3'd3:    p = 17'd1000;
         3'd4:    p = 17'd10000;
         default: p = 17'd0;
      endcase
      return p;
   endfunction

   function automatic logic [3:0] dec_digit(input logic [15:0] r, input logic [2:0] place);
      logic [3:0] d;
      d = '0;
      for (int m = 1; m <= 9; m++) begin
         if ({1'b0, r} >= 17'(m) * pow10(place)) begin
            d = 4'(m);
         end
      end
      return d;
   endfunction

   function automatic logic [15:0] dec_rest(input logic [15:0] r, input logic [2:0] place);
      logic [16:0] sub;
      sub = '0;
      for (int m = 1; m <= 9; m++) begin
         if ({1'b0, r} >= 17'(m) * pow10(place)) begin
            sub = 17'(m) * pow10(place);
         end
      end
      return 16'({1'b0, r} - sub);
   endfunction

   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = lcdnw_pkg::LCD_FUNC_SET;
         2'd1: b = lcdnw_pkg::LCD_DISP_ON;
         2'd2: b = lcdnw_pkg::LCD_ENTRY;
         2'd3: b = lcdnw_pkg::LCD_CLEAR;
      endcase
      return b;
   endfunction

   logic                        busy_ff, busy_in;
   lcdnw_pkg::phase_type        phase_ff, phase_in;
   lcdnw_pkg::op_type           kind_ff, kind_in;
   logic [7:0]                  addr_ff, addr_in;
   logic [15:0]                 val_ff, val_in;
   logic                        pos_ff, pos_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [2:0]                  place_ff, place_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lcdnw_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                        slot_free, emit, step, done_now, is_dec;
   logic [4:0]                  cnt5, p5;
   logic [2:0]                  dec_place;
   logic [3:0]                  dec_d, hex_d;
   logic [15:0]                 dec_r;
   lcdnw_pkg::phase_type        digit_start;
   logic [7:0]                  out_byte, digit_char;
   logic                        out_data, out_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && (phase_ff != lcdnw_pkg::PH_SKIP);
   assign step      = busy_ff && ((phase_ff == lcdnw_pkg::PH_SKIP) || slot_free);
   assign is_dec    = (kind_ff == lcdnw_pkg::OP_UDEC) || (kind_ff == lcdnw_pkg::OP_SDEC);
   assign cnt5      = 5'(cnt_ff);
   assign p5        = cnt5 - 5'd1;
   assign dec_place = (phase_ff == lcdnw_pkg::PH_SKIP) ? place_ff : p5[2:0];
   assign dec_d     = dec_digit(val_ff, dec_place);
   assign dec_r     = dec_rest(val_ff, dec_place);
   assign hex_d     = val_ff[{p5[1:0], 2'b00} +: 4];

   // decimal with fewer places than the value can fill: drop the high places first
   always_comb begin
      if (is_dec && cnt5 != 5'd0 && cnt5 < 5'(lcdnw_pkg::DEC_PLACES)) begin
         digit_start = lcdnw_pkg::PH_SKIP;
      end else begin
         digit_start = lcdnw_pkg::PH_DIGIT;
      end
   end

   always_comb begin
      digit_char = lcdnw_pkg::CHAR_ZERO;
      unique case (kind_ff)
         lcdnw_pkg::OP_UDEC, lcdnw_pkg::OP_SDEC: begin
            if (p5 < 5'(lcdnw_pkg::DEC_PLACES)) begin
               digit_char = lcdnw_pkg::CHAR_ZERO + 8'(dec_d);
            end
         end
         lcdnw_pkg::OP_HEX: begin
            if (p5 < 5'd4) begin
               digit_char = (hex_d < 4'd10) ? lcdnw_pkg::CHAR_ZERO + 8'(hex_d)
                                            : lcdnw_pkg::CHAR_A + 8'(hex_d) - 8'd10;
            end
         end
         lcdnw_pkg::OP_BIN: digit_char = lcdnw_pkg::CHAR_ZERO + 8'(val_ff[p5[3:0]]);
         default:           digit_char = lcdnw_pkg::CHAR_ZERO;
      endcase
   end

   // byte for the current phase
   always_comb begin
      out_byte = '0;
      out_data = 1'b0;
      out_last = 1'b0;
      unique case (phase_ff)
         lcdnw_pkg::PH_INIT: begin
            out_byte = init_byte(idx_ff);
            out_last = (idx_ff == 2'd3);
         end
         lcdnw_pkg::PH_ADDR: begin
            out_byte = addr_ff;
            out_last = (kind_ff != lcdnw_pkg::OP_CHAR) && (kind_ff != lcdnw_pkg::OP_SDEC)
                       && (cnt5 == 5'd0);
         end
         lcdnw_pkg::PH_CHAR: begin
            out_byte = val_ff[7:0];
            out_data = 1'b1;
            out_last = 1'b1;
         end
         lcdnw_pkg::PH_SIGN: begin
            out_byte = pos_ff ? lcdnw_pkg::CHAR_PLUS : lcdnw_pkg::CHAR_MINUS;
            out_data = 1'b1;
            out_last = (cnt5 == 5'd0);
         end
         lcdnw_pkg::PH_SKIP: begin
            out_byte = '0;
         end
         lcdnw_pkg::PH_DIGIT: begin
            out_byte = digit_char;
            out_data = 1'b1;
            out_last = (cnt5 == 5'd1);
         end
         default: out_byte = '0;
      endcase
   end

   assign done_now = step && emit && out_last;
   assign q_pop    = q_valid && (!busy_ff || done_now);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (q_pop) begin
         phase_in = (q_job.kind == lcdnw_pkg::OP_INIT) ? lcdnw_pkg::PH_INIT
                                                       : lcdnw_pkg::PH_ADDR;
      end else if (step) begin
         unique case (phase_ff)
            lcdnw_pkg::PH_ADDR: begin
               if (kind_ff == lcdnw_pkg::OP_CHAR) begin
                  phase_in = lcdnw_pkg::PH_CHAR;
               end else if (kind_ff == lcdnw_pkg::OP_SDEC) begin
                  phase_in = lcdnw_pkg::PH_SIGN;
               end else begin
                  phase_in = digit_start;
               end
            end
            lcdnw_pkg::PH_SIGN:  phase_in = digit_start;
            lcdnw_pkg::PH_SKIP:  phase_in = (5'(place_ff) > cnt5) ? lcdnw_pkg::PH_SKIP
                                                                  : lcdnw_pkg::PH_DIGIT;
            lcdnw_pkg::PH_INIT,
            lcdnw_pkg::PH_CHAR,
            lcdnw_pkg::PH_DIGIT: phase_in = phase_ff;
            default:             phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      busy_in  = q_pop ? 1'b1 : (done_now ? 1'b0 : busy_ff);
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      place_in = place_ff;
      idx_in   = idx_ff;
      if (q_pop) begin
         kind_in  = q_job.kind;
         addr_in  = q_job.addr_byte;
         val_in   = q_job.value;
         pos_in   = q_job.positive;
         cnt_in   = q_count;
         place_in = 3'(lcdnw_pkg::DEC_PLACES - 1);
         idx_in   = '0;
      end else if (step) begin
         if (phase_ff == lcdnw_pkg::PH_INIT) begin
            idx_in = idx_ff + 2'd1;
         end
         if (phase_ff == lcdnw_pkg::PH_SKIP) begin
            val_in   = dec_r;
            place_in = place_ff - 3'd1;
         end
         if (phase_ff == lcdnw_pkg::PH_DIGIT) begin
            cnt_in = cnt_ff - 1'b1;
            if (is_dec && p5 < 5'(lcdnw_pkg::DEC_PLACES)) begin
               val_in = dec_r;
            end
         end
      end
   end

   // output stage: load whenever the held transfer has gone
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (slot_free) begin
         rsp_valid_in            = emit;
         rsp_payload_in.is_data  = out_data;
         rsp_payload_in.bus_byte = out_byte;
         rsp_payload_in.last     = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= lcdnw_pkg::PH_ADDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      addr_ff        <= addr_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      cnt_ff         <= cnt_in;
      place_ff       <= place_in;
      idx_ff         <= idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/char_lcd_number_writer_unit.sv
// The first byte write of a request passes the job queue, the sequencer and the registered output stage.
// Throughput: one byte write per cycle while rsp_stall is low; a request gives 1 to 18
//   writes, and decimal with 1 to 4 digits first drops the high places without a write,
//   in the single byte sequencer that walks the digit places.
// Requests are taken every cycle while the two-entry job queue has room.
// Reset: synchronous; clears the queue, the sequencer and the output stage.
// ----------------------------------------------------------------------------
// char_lcd_number_writer_unit: character LCD number writer
// Turns display requests into command and data byte writes for an
// HD44780-style controller; decode, job queue and byte sequencer.
// ----------------------------------------------------------------------------
module char_lcd_number_writer_unit #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lcdnw_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lcdnw_pkg::rsp_payload_type  rsp_payload
);

   localparam int CntW = $clog2(MAX_DIGITS + 1);
   localparam int QW   = $bits(lcdnw_pkg::job_type) + CntW;

   logic                 keep, q_full, q_pop, q_valid, push;
   lcdnw_pkg::job_type   front_job, q_job;
   logic [CntW-1:0]      front_count, q_count;
   logic [QW-1:0]        q_data;

   lcdnw_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .req_payload (req_payload),
      .keep        (keep),
      .job         (front_job),
      .count       (front_count)
   );

   // unknown commands complete the transfer and are dropped
   assign push      = req_valid && !q_full && keep;
   assign req_stall = q_full;

   lcdnw_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_job, front_count}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   assign q_job   = q_data[QW-1:CntW];
   assign q_count = q_data[CntW-1:0];

   lcdnw_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_job       (q_job),
      .q_count     (q_count),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/lcdnw_checker.sv
// ----------------------------------------------------------------------------
// lcdnw_checker: port-level checks for the LCD number writer
// Watches the result channel for sequencing and handshake slips.
// ----------------------------------------------------------------------------
module lcdnw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input lcdnw_pkg::rsp_payload_type  rsp_payload
);

   logic first_ff, first_in;
   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // next transfer opens a request
   always_comb begin
      first_in = first_ff;
      if (rsp_xfer) begin
         first_in = rsp_payload.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   a_opens_with_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && first_ff |-> !rsp_payload.is_data)
      else $error("request did not open with a command byte");

   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_payload.is_data && rsp_payload.last |->
      (rsp_payload.bus_byte == lcdnw_pkg::LCD_CLEAR) || rsp_payload.bus_byte[7])
      else $error("final command byte is neither clear nor set-address");

endmodule

bind char_lcd_number_writer_unit lcdnw_checker u_checker (.*);

FILE: dv/char_lcd_number_writer_unit_test.sv
// ----------------------------------------------------------------------------
// char_lcd_number_writer_unit_test: self-checking bench for the LCD writer
// Drives display requests through the request channel, predicts the command
// and data byte writes each one should give, and checks every write on the
// response channel in order. Both sides idle at random until the tail.
// ----------------------------------------------------------------------------
module char_lcd_number_writer_unit_test;

   localparam int DIGIT_LIMIT = 16;
   localparam int RANDOM_REQUESTS = 78;
   localparam int QUIET_TAIL = 15;     // requests sent at the end with no idling
   localparam int DRAIN_CYCLES = 24;
   localparam int IDLE_LIMIT = 2000;
   localparam int SHOWN_FAULTS = 10;

   // request codes the block ignores
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   lcdnw_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   lcdnw_pkg::rsp_payload_type rsp_payload;

   lcdnw_pkg::req_payload_type requests_to_send[$];
   lcdnw_pkg::rsp_payload_type lcd_writes_due[$];
   int              requests_taken = 0;
   int              fault_count = 0;
   int              tx_gap = 0;
   int              tx_calm = 0;
   int              rx_hold = 0;
   int              rx_calm = 0;
   logic            idling_on;

   char_lcd_number_writer_unit #(
      .MAX_DIGITS (DIGIT_LIMIT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial forever #4 clock = ~clock;

   assign idling_on = requests_to_send.size() > QUIET_TAIL;

   function automatic lcdnw_pkg::req_payload_type make_request(logic [2:0] op,
                                                               logic [1:0] ln,
                                                               logic [5:0] col,
                                                               logic [15:0] val,
                                                               logic [4:0] cnt);
      lcdnw_pkg::req_payload_type rq;
      rq.cmd = op;
      rq.line = ln;
      rq.column = col;
      rq.value = val;
      rq.digit_count = cnt;
      return rq;
   endfunction

   // Work out the byte writes one request gives and queue them up.
   function automatic void predict_writes(lcdnw_pkg::req_payload_type rq);
      lcdnw_pkg::rsp_payload_type seq [0:17];
      int              n;
      int              places;
      int              p;
      int              k;
      logic [7:0]      addr;
      logic [15:0]     mag;
      logic [7:0]      ch;
      longint unsigned radix;
      longint unsigned scale;
      longint unsigned d;
      n = 0;
      if (rq.cmd == CMD_RSVD6 || rq.cmd == CMD_RSVD7) return;
      if (rq.cmd == lcdnw_pkg::CMD_INIT) begin
         seq[0] = '{1'b0, lcdnw_pkg::LCD_FUNC_SET, 1'b0};
         seq[1] = '{1'b0, lcdnw_pkg::LCD_DISP_ON, 1'b0};
         seq[2] = '{1'b0, lcdnw_pkg::LCD_ENTRY, 1'b0};
         seq[3] = '{1'b0, lcdnw_pkg::LCD_CLEAR, 1'b0};
         n = 4;
      end else begin
         places = (rq.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(rq.digit_count);
         // column zero wraps around the 8-bit address range
         addr = {2'b00, rq.column} - 8'd1;
         if (rq.line != 2'd1) addr = addr + lcdnw_pkg::LCD_LINE2;
         seq[0] = '{1'b0, lcdnw_pkg::LCD_SET_ADDR | addr, 1'b0};
         n = 1;
         mag = rq.value;
         if (rq.cmd == lcdnw_pkg::CMD_CHAR) begin
            seq[1] = '{1'b1, rq.value[7:0], 1'b0};
            n = 2;
         end else begin
            if (rq.cmd == lcdnw_pkg::CMD_SDEC) begin
               // zero takes the minus sign too
               if (mag != 16'd0 && !mag[15]) begin
                  seq[n] = '{1'b1, lcdnw_pkg::CHAR_PLUS, 1'b0};
               end else begin
                  seq[n] = '{1'b1, lcdnw_pkg::CHAR_MINUS, 1'b0};
                  mag = 16'd0 - mag;
               end
               n = n + 1;
            end
            radix = (rq.cmd == lcdnw_pkg::CMD_HEX) ? 64'd16
                  : (rq.cmd == lcdnw_pkg::CMD_BIN) ? 64'd2 : 64'd10;
            for (p = places; p > 0; p--) begin
               scale = 1;
               for (k = 0; k < p - 1; k++) scale = scale * radix;
               d = (64'(mag) / scale) % radix;
               ch = (d < 10) ? 8'(lcdnw_pkg::CHAR_ZERO + d)
                             : 8'(lcdnw_pkg::CHAR_A + d - 10);
               seq[n] = '{1'b1, ch, 1'b0};
               n = n + 1;
            end
         end
      end
      seq[n - 1].last = 1'b1;
      for (k = 0; k < n; k++) lcd_writes_due.push_back(seq[k]);
   endfunction

   function automatic void check_write(lcdnw_pkg::rsp_payload_type got);
      lcdnw_pkg::rsp_payload_type want;
      if (lcd_writes_due.size() == 0) begin
         fault_count++;
         if (fault_count <= SHOWN_FAULTS)
            $display("unexpected write: is_data %0b byte %02h last %0b",
                     got.is_data, got.bus_byte, got.last);
         return;
      end
      want = lcd_writes_due.pop_front();
      if (got.is_data != want.is_data || got.bus_byte != want.bus_byte
          || got.last != want.last) begin
         fault_count++;
         if (fault_count <= SHOWN_FAULTS)
            $display("write mismatch: expected is_data %0b byte %02h last %0b, got %0b %02h %0b",
                     want.is_data, want.bus_byte, want.last,
                     got.is_data, got.bus_byte, got.last);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_writes(req_payload);
            requests_taken++;
         end
         // hold the payload while stalled
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (requests_to_send.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idling_on && tx_calm == 0 && $urandom_range(0, 4) == 0) begin
               tx_gap = $urandom_range(1, 18) - 1;
               tx_calm = $urandom_range(1, 30);
               req_valid <= 1'b0;
            end else begin
               if (tx_calm > 0) tx_calm--;
               req_valid <= 1'b1;
               req_payload <= requests_to_send.pop_front();
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_write(rsp_payload);
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_calm > 0) begin
            rx_calm--;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 18) - 1;
            rx_calm = $urandom_range(1, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // end the run if no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int          i;
      int          total;
      logic [2:0]  op;
      logic [1:0]  ln;
      logic [5:0]  col;
      logic [15:0] val;
      logic [4:0]  cnt;

      // directed: extremes, every request code and the corner cases
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_INIT, 2'd1, 6'd1, 16'h0000, 5'd0));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_CHAR, 2'd1, 6'd1, 16'h5A41, 5'd0));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_CHAR, 2'd2, 6'd40, 16'hFFFF, 5'd31));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_CHAR, 2'd1, 6'd0, 16'h0030, 5'd1));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_UDEC, 2'd2, 6'd0, 16'd42, 5'd2));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_HEX, 2'd3, 6'd63, 16'hFFFF, 5'd31));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_BIN, 2'd0, 6'd17, 16'hA5C3, 5'd16));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_UDEC, 2'd1, 6'd5, 16'hFFFF, 5'd5));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_UDEC, 2'd2, 6'd9, 16'h0000, 5'd16));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_SDEC, 2'd1, 6'd1, 16'h0000, 5'd5));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_SDEC, 2'd1, 6'd2, 16'h0001, 5'd5));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_SDEC, 2'd2, 6'd3, 16'h8000, 5'd6));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_SDEC, 2'd2, 6'd4, 16'hFFFF, 5'd1));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_SDEC, 2'd1, 6'd20, 16'h7FFF, 5'd16));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_HEX, 2'd1, 6'd7, 16'h0000, 5'd0));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_SDEC, 2'd2, 6'd8, 16'h1234, 5'd0));
      requests_to_send.push_back(make_request(CMD_RSVD6, 2'd1, 6'd1, 16'h1111, 5'd4));
      requests_to_send.push_back(make_request(CMD_RSVD7, 2'd2, 6'd2, 16'h2222, 5'd4));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_UDEC, 2'd1, 6'd30, 16'd12345, 5'd3));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_HEX, 2'd2, 6'd12, 16'hBEEF, 5'd4));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_BIN, 2'd1, 6'd39, 16'h0001, 5'd1));
      requests_to_send.push_back(make_request(lcdnw_pkg::CMD_INIT, 2'd3, 6'd63, 16'hFFFF, 5'd31));

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(0, 19) == 0) op = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
         else op = 3'($urandom_range(lcdnw_pkg::CMD_INIT, lcdnw_pkg::CMD_BIN));
         ln = 2'($urandom_range(0, 3));
         col = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 40));
         case ($urandom_range(0, 7))
            0: val = 16'h0000;
            1: val = 16'hFFFF;
            2: val = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: val = 16'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0: cnt = 5'($urandom_range(17, 31));
            1: cnt = 5'd0;
            default: cnt = 5'($urandom_range(1, 16));
         endcase
         requests_to_send.push_back(make_request(op, ln, col, val, cnt));
      end
      total = requests_to_send.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < total || lcd_writes_due.size() > 0) @(posedge clock);
      // let any stray writes show before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && lcd_writes_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
